// ----- design/cfes_pkg.sv -----
// ----------------------------------------------------------------------------
// cfes_pkg
// Shared types and constants for the ring-buffer FIFO with end swap:
// operation and status codes, sequencer states and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package cfes_pkg;

    // Width of one stored word and of the reported count.
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;

    // Operation codes carried with each input beat.
    typedef enum logic [2:0] {
        FUNC_PUSH     = 3'd0,
        FUNC_POP      = 3'd1,
        FUNC_REP_HEAD = 3'd2,
        FUNC_REP_TAIL = 3'd3,
        FUNC_SWAP     = 3'd4,
        FUNC_PEEK     = 3'd5
    } func_t;

    // Status codes returned with each result beat.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWAP2
    } state_t;

    // One result item.
    typedef struct packed {
        status_t                    status;
        logic                       is_full;
        logic                       is_empty;
        logic [COUNT_W-1:0]         item_count;
        logic signed [DATA_W-1:0]   tail_value;
        logic signed [DATA_W-1:0]   out_value;
    } res_t;

endpackage : cfes_pkg

`default_nettype wire

// ----- design/cfes_ram.sv -----
// ----------------------------------------------------------------------------
// cfes_ram
// Slot store: one write port and two read ports with registered read data.
// Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
`default_nettype none

module cfes_ram
    import cfes_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic signed [DATA_W-1:0] wr_data,
    input  wire logic                     rd_en,
    input  wire logic [AW-1:0]            rd_addr_a,
    input  wire logic [AW-1:0]            rd_addr_b,
    output logic signed [DATA_W-1:0]      rd_data_a,
    output logic signed [DATA_W-1:0]      rd_data_b
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule : cfes_ram

`default_nettype wire

// ----- design/cfes_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfes_ctrl
// Sequencer of the FIFO: keeps head, tail and count, reads both ends of the
// slot store, applies the operation and writes back, then hands one result.
// ----------------------------------------------------------------------------
`default_nettype none

module cfes_ctrl
    import cfes_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int CW    = 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // Operation input
    input  wire logic                     op_valid,
    output logic                          op_ready,
    input  wire func_t                    op_func,
    input  wire logic signed [DATA_W-1:0] op_value,
    // Result output
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output res_t                          res,
    // Slot store
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic signed [DATA_W-1:0]      wr_data,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr_a,
    output logic [AW-1:0]                 rd_addr_b,
    input  wire logic signed [DATA_W-1:0] rd_data_a,
    input  wire logic signed [DATA_W-1:0] rd_data_b
);

    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    state_t                   state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            count_reg, count_next;
    func_t                    func_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic                     accept;
    logic                     empty;
    logic                     full;
    logic [AW-1:0]            head_inc;
    logic [AW-1:0]            tail_inc;
    status_t                  status;
    logic signed [DATA_W-1:0] res_a;
    logic signed [DATA_W-1:0] res_b;

    // Ring increments and end flags.
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_CNT);

    // An item enters only when the sequencer is idle; both ends are read then.
    assign op_ready  = (state_reg == ST_IDLE);
    assign accept    = op_valid && op_ready;
    assign rd_en     = accept;
    assign rd_addr_a = head_reg;
    assign rd_addr_b = tail_reg;
    assign res_valid = (state_reg == ST_EXEC);

    // Next state, write-back and result.
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        wr_data    = value_reg;
        status     = STATUS_OK;
        res_a      = '0;
        res_b      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                case (func_reg)
                    FUNC_PUSH:
                    begin
                        if (full)
                        begin
                            status = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en      = res_ready;
                            wr_addr    = tail_inc;
                            tail_next  = tail_inc;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    FUNC_POP:
                    begin
                        if (empty)
                        begin
                            status = STATUS_EMPTY;
                        end
                        else
                        begin
                            res_a      = rd_data_a;
                            head_next  = head_inc;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    FUNC_REP_HEAD:
                    begin
                        if (empty)
                        begin
                            status = STATUS_EMPTY;
                        end
                        else
                        begin
                            res_a = rd_data_a;
                            wr_en = res_ready;
                        end
                    end
                    FUNC_REP_TAIL:
                    begin
                        if (empty)
                        begin
                            status = STATUS_EMPTY;
                        end
                        else
                        begin
                            wr_en   = res_ready;
                            wr_addr = tail_reg;
                        end
                    end
                    FUNC_SWAP:
                    begin
                        // The old tail goes to the head now, the old head to
                        // the tail in the following cycle.
                        if (empty)
                        begin
                            status = STATUS_EMPTY;
                        end
                        else
                        begin
                            wr_en   = res_ready;
                            wr_data = rd_data_b;
                        end
                    end
                    FUNC_PEEK:
                    begin
                        if (empty)
                        begin
                            status = STATUS_EMPTY;
                        end
                        else
                        begin
                            res_a = rd_data_a;
                            res_b = rd_data_b;
                        end
                    end
                    default:
                    begin
                        status = STATUS_OK;
                    end
                endcase

                if (res_ready)
                begin
                    state_next = (func_reg == FUNC_SWAP && !empty) ? ST_SWAP2 : ST_IDLE;
                end
                else
                begin
                    head_next  = head_reg;
                    tail_next  = tail_reg;
                    count_next = count_reg;
                end
            end

            ST_SWAP2:
            begin
                wr_en      = 1'b1;
                wr_addr    = tail_reg;
                wr_data    = rd_data_a;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result word, flags taken from the count after the operation.
    always_comb
    begin
        res.out_value  = res_a;
        res.tail_value = res_b;
        res.item_count = COUNT_W'(count_next);
        res.is_empty   = (count_next == '0);
        res.is_full    = (count_next == FULL_CNT);
        res.status     = status;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= LAST_IDX;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Captured operation.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= op_func;
            value_reg <= op_value;
        end
    end

    // The count never passes the depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("word count above depth");

    // An accepted item always goes to the execute step.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted item not executed");

    // A stalled result leaves the queue state untouched.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && !res_ready) |=>
            ($stable(count_reg) && $stable(head_reg) && $stable(tail_reg)))
        else $error("queue state moved while result stalled");

    // The second swap write lasts one cycle.
    a_swap_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAP2) |=> (state_reg == ST_IDLE))
        else $error("swap write-back did not finish");

    // Only the execute step moves the count, by one at most.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_EXEC) |=> $stable(count_reg))
        else $error("count changed outside execute step");

endmodule : cfes_ctrl

`default_nettype wire

// ----- design/circular_fifo_with_end_swap.sv -----
// ----------------------------------------------------------------------------
// circular_fifo_with_end_swap
// Ring-buffer FIFO of signed 32-bit words with push, pop, end replace,
// end swap and peek, one result beat per operation beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: func[2:0]; tdata: value[31:0]
//  m_axis    out        tdata: out_value, tail_value, item_count, is_empty,
//                              is_full, status, zero pad to 80 bits
//
//  An operation goes from accept through the execute step to the result
//  register; a swap holds the input in ST_SWAP2 for its second slot write.
//  Both ends are read in the accept cycle and written back in the execute
//  step once the result register can load. The result register frees the
//  sequencer as soon as it is loaded; a stalled result keeps the sequencer
//  in its execute step. Reset sets head and count to zero and tail to the
//  last slot at once; stored words are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_with_end_swap
    import cfes_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value[31:0]
    input  wire logic [2:0]  s_tuser,   // func[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_value[31:0], tail_value[63:32], item_count[71:64], is_empty[72],
    // is_full[73], status[75:74], zero[79:76]
    output logic [79:0]      m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr_a;
    logic [AW-1:0]            rd_addr_b;
    logic signed [DATA_W-1:0] rd_data_a;
    logic signed [DATA_W-1:0] rd_data_b;
    logic                     res_valid;
    logic                     res_ready;
    res_t                     res;
    logic                     m_valid_reg;
    res_t                     m_data_reg;

    cfes_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (s_tvalid),
        .op_ready  (s_tready),
        .op_func   (func_t'(s_tuser)),
        .op_value  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    cfes_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Result register: loads whenever it is empty or being drained.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};

endmodule : circular_fifo_with_end_swap

`default_nettype wire

// ----- tb/tb_circular_fifo_with_end_swap.sv -----
// ----------------------------------------------------------------------------
// tb_circular_fifo_with_end_swap
// Self-checking bench for the ring-buffer FIFO with end swap. Operation
// beats go in on the slave stream and a shadow ring predicts every result
// beat. The stimulus is a directed opening and then random operation mixes
// biased toward filling or draining, under changing sender and receiver
// idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circular_fifo_with_end_swap;

    import cfes_pkg::*;

    localparam int DEPTH       = 128;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 20;

    // Operation codes that the block treats as no-ops.
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    typedef struct {
        logic [2:0]  code;
        logic [31:0] word;
    } op_beat_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    // Operations waiting to be offered, and results predicted but not yet seen.
    op_beat_t pending_ops[$];
    res_t     expected_results[$];

    // Shadow copy of the ring.
    logic signed [31:0] shadow_ring [DEPTH];
    int shadow_head  = 0;
    int shadow_tail  = DEPTH - 1;
    int shadow_level = 0;

    // Idling controls, set by the stimulus process.
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int rx_hold_cycles  = 0;

    bit op_taken    = 1'b0;
    int error_count = 0;
    int cycle_count = 0;

    // Coverage tallies for the closing summary.
    int func_hits [8];
    int dropped_pushes = 0;
    int refused_ops    = 0;
    int peak_level     = 0;
    int results_seen   = 0;

    circular_fifo_with_end_swap #(.DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // value[31:0]
        .s_tuser  (s_tuser),    // func[2:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // out_value, tail_value, item_count, is_empty, is_full, status, pad
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    always #10 clk = ~clk;

    // Run-time watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Applies one operation to the shadow ring and returns its result beat.
    function automatic res_t fifo_apply(logic [2:0] code, logic signed [31:0] word);
        res_t               r;
        logic signed [31:0] held;
        r        = '0;
        r.status = STATUS_OK;
        if (code == FUNC_PUSH)
        begin
            if (shadow_level >= DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                shadow_tail = (shadow_tail + 1) % DEPTH;
                shadow_ring[shadow_tail] = word;
                shadow_level++;
            end
        end
        else if (code <= FUNC_PEEK)
        begin
            if (shadow_level == 0)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                case (code)
                    FUNC_POP:
                    begin
                        r.out_value = shadow_ring[shadow_head];
                        shadow_head = (shadow_head + 1) % DEPTH;
                        shadow_level--;
                    end
                    FUNC_REP_HEAD:
                    begin
                        r.out_value = shadow_ring[shadow_head];
                        shadow_ring[shadow_head] = word;
                    end
                    FUNC_REP_TAIL:
                    begin
                        shadow_ring[shadow_tail] = word;
                    end
                    FUNC_SWAP:
                    begin
                        held = shadow_ring[shadow_head];
                        shadow_ring[shadow_head] = shadow_ring[shadow_tail];
                        shadow_ring[shadow_tail] = held;
                    end
                    default:
                    begin
                        r.out_value  = shadow_ring[shadow_head];
                        r.tail_value = shadow_ring[shadow_tail];
                    end
                endcase
            end
        end
        r.item_count = 8'(shadow_level);
        r.is_empty   = (shadow_level == 0);
        r.is_full    = (shadow_level >= DEPTH);
        return r;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= 40)
        begin
            $display("Mismatch at cycle %0d, result %0d: %s got %h, expected %h",
                     cycle_count, results_seen, field, got, want);
        end
    endtask

    // Sender: offers the queue head, holds it until accepted, idles at random.
    always @(negedge clk)
    begin
        bit taken;
        taken    = op_taken;
        op_taken = 1'b0;
        if (taken)
        begin
            void'(pending_ops.pop_front());
        end
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !taken)
        begin
            s_tvalid <= 1'b1;
        end
        else if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            s_tvalid <= 1'b1;
            s_tuser  <= pending_ops[0].code;
            s_tdata  <= pending_ops[0].word;
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: long hold-off when requested, otherwise random stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (rx_hold_cycles > 0)
        begin
            rx_hold_cycles--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Input monitor: predicts the result of every accepted operation beat.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && s_tvalid && s_tready)
        begin
            want = fifo_apply(s_tuser, s_tdata);
            expected_results.push_back(want);
            op_taken = 1'b1;
            func_hits[s_tuser]++;
            if (want.status == STATUS_FULL)
                dropped_pushes++;
            if (want.status == STATUS_EMPTY)
                refused_ops++;
            if (shadow_level > peak_level)
                peak_level = shadow_level;
        end
    end

    // Output monitor: compares every result beat with the oldest prediction.
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got = res_t'(m_tdata[75:0]);
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected beat", m_tdata[31:0], '0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.out_value !== want.out_value)
                    report_mismatch("out_value", got.out_value, want.out_value);
                if (got.tail_value !== want.tail_value)
                    report_mismatch("tail_value", got.tail_value, want.tail_value);
                if (got.item_count !== want.item_count)
                    report_mismatch("item_count", 32'(got.item_count), 32'(want.item_count));
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
                if (got.is_full !== want.is_full)
                    report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (m_tdata[79:76] !== 4'b0)
                    report_mismatch("pad bits", 32'(m_tdata[79:76]), '0);
            end
        end
    end

    // Queues one operation beat for the sender.
    task automatic add_op(logic [2:0] code, logic [31:0] word);
        op_beat_t b;
        b.code = code;
        b.word = word;
        pending_ops.push_back(b);
    endtask

    // Data word with the extremes showing up often.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Operation code with a given share of pushes and rare reserved codes.
    function automatic logic [2:0] pick_func(int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            return FUNC_PUSH;
        case ($urandom_range(0, 49))
            0:       return FUNC_RSVD6;
            1:       return FUNC_RSVD7;
            default:
            begin
                case ($urandom_range(0, 5))
                    0, 1:    return FUNC_POP;
                    2:       return FUNC_REP_HEAD;
                    3:       return FUNC_REP_TAIL;
                    4:       return FUNC_SWAP;
                    default: return FUNC_PEEK;
                endcase
            end
        endcase
    endfunction

    // Stimulus pause: waits until every queued beat is in and every result out.
    task automatic wait_drained();
        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // One random phase of operations under the given idling.
    task automatic run_mix(int count, int push_pct, int send_idle, int recv_stall);
        @(posedge clk);
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        for (int i = 0; i < count; i++)
            add_op(pick_func(push_pct), pick_word());
        wait_drained();
    endtask

    // Stimulus sequence.
    initial
    begin
        string mix_line;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening: every refusal on an empty queue, reserved codes,
        // the extreme words, a swap with a single word and a swap of two.
        add_op(FUNC_POP,      32'h1234_5678);
        add_op(FUNC_REP_HEAD, 32'h1111_1111);
        add_op(FUNC_REP_TAIL, 32'h2222_2222);
        add_op(FUNC_SWAP,     32'h0);
        add_op(FUNC_PEEK,     32'h0);
        add_op(FUNC_RSVD6,    32'hFFFF_FFFF);
        add_op(FUNC_RSVD7,    32'hFFFF_FFFF);
        add_op(FUNC_PUSH,     32'h7FFF_FFFF);
        add_op(FUNC_SWAP,     32'h0);
        add_op(FUNC_PEEK,     32'h0);
        add_op(FUNC_PUSH,     32'h8000_0000);
        add_op(FUNC_SWAP,     32'h0);
        add_op(FUNC_PEEK,     32'h0);
        add_op(FUNC_REP_HEAD, 32'h0000_0000);
        add_op(FUNC_REP_TAIL, 32'hFFFF_FFFF);
        add_op(FUNC_PEEK,     32'h0);
        add_op(FUNC_POP,      32'h0);
        add_op(FUNC_POP,      32'h0);
        add_op(FUNC_POP,      32'h0);
        add_op(FUNC_PUSH,     32'h0000_0000);
        add_op(FUNC_PUSH,     32'hFFFF_FFFF);
        add_op(FUNC_PEEK,     32'h0);
        wait_drained();

        // Fill past full so that pushes get dropped, with no idling.
        run_mix(200, 85, 0, 0);
        run_mix(250, 50, 57, 0);
        run_mix(250, 45, 0, 57);
        run_mix(250, 50, 26, 26);

        // Receiver holds off for a long stretch while the sender keeps going.
        @(posedge clk);
        rx_hold_cycles = 300;
        run_mix(150, 60, 0, 0);

        // Drain down to empty, then refill at the top under stalls.
        run_mix(250, 15, 26, 26);
        run_mix(200, 80, 0, 57);
        run_mix(200, 20, 57, 0);

        repeat (SETTLE) @(posedge clk);
        mix_line = $sformatf("push %0d, pop %0d, replace head %0d, replace tail %0d,",
                             func_hits[0], func_hits[1], func_hits[2], func_hits[3]);
        $display("Ran %0d operation beats: %s swap %0d, peek %0d, reserved %0d.",
                 results_seen, mix_line, func_hits[4], func_hits[5],
                 func_hits[6] + func_hits[7]);
        $display("Dropped pushes %0d, refused on empty %0d, peak fill %0d of %0d.",
                 dropped_pushes, refused_ops, peak_level, DEPTH);
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches found.", error_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule : tb_circular_fifo_with_end_swap

`default_nettype wire
